// File: sv/sbta_pkg.sv
// shared types and constants for the slot boundary-tag allocator
// no dependencies; imported by sbta_tag_ram, slot_boundary_tag_allocator and the testbench
package sbta_pkg;

  localparam int MAX_SLOTS  = 512;
  localparam int SLOT_W     = 9;    // slot index width
  localparam int PTR_W      = 10;   // slot pointer width, holds MAX_SLOTS and a bit past
  localparam int TAG_W      = 8;    // signed boundary tag
  localparam int LEN_W      = 8;    // tag magnitude, up to 128
  localparam int NEED_W     = 7;    // slots per request, up to FIELD_MAX
  localparam int TOTAL_W    = 9;    // merged run length
  localparam int FIELD_MAX  = 127;
  localparam int SLOT_SHIFT = 3;    // log2 of the slot size in bytes
  localparam int SLOT_BYTES = 1 << SLOT_SHIFT;
  localparam int MAX_BYTES  = FIELD_MAX * SLOT_BYTES - 2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [TAG_W-1:0] data;
  } tag_wr_t;

endpackage

// File: sv/sbta_tag_ram.sv
// boundary tag memory: one write and one registered read per cycle
// one entry reads a fixed tag until first written; depends on sbta_pkg
module sbta_tag_ram
  import sbta_pkg::*;
#(
  parameter int               INIT_ADDR = 0,
  parameter logic [TAG_W-1:0] INIT_TAG  = 8'h81
) (
  input  logic             clk,
  input  logic             rst,
  input  tag_wr_t          wr,
  input  logic [PTR_W-1:0] raddr,
  output logic [TAG_W-1:0] rdata
);

  logic [TAG_W-1:0] mem [MAX_SLOTS];
  logic [TAG_W-1:0] mem_q;
  logic             init_written;
  logic             rd_init;
  logic             rd_out;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr < PTR_W'(MAX_SLOTS))) begin
      mem[wr.addr[SLOT_W-1:0]] <= wr.data;
    end
    mem_q   <= mem[raddr[SLOT_W-1:0]];
    rd_out  <= (raddr >= PTR_W'(MAX_SLOTS));
    rd_init <= (raddr == PTR_W'(INIT_ADDR)) && !init_written;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_written <= 1'b0;
    end else if (wr.en && (wr.addr == PTR_W'(INIT_ADDR))) begin
      init_written <= 1'b1;
    end
  end

  // out-of-range reads give zero
  assign rdata = rd_out ? '0 : (rd_init ? INIT_TAG : mem_q);

endmodule

// File: sv/slot_boundary_tag_allocator.sv
// slot boundary-tag allocator top level: sequencer, pointer unit, output register
// depends on sbta_pkg and sbta_tag_ram
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  action, byte_count, field_slot
//   out       source     out_valid/out_stall  granted_slot, success
//   apb       slave      psel/penable/pready  heap_slots at byte address 0
//
// after acceptance an allocation reads and evaluates each field walked from the search
// hint, then finishes a fit, splits a larger free field or extends the used end
// in ST_X_READ, ST_X_EVAL and ST_X_CHK; a rejected size goes straight to ST_FIN. a free
// merges with free neighbours and writes each 127-slot piece in ST_F_WR. each memory
// has one read port. ST_FIN repeats while the output register holds a stalled result
// rst is synchronous and restores the initial 127-slot free field, hint 0
// the block takes one transaction at a time; a finished result waits in the
// output register while the next transaction is accepted
module slot_boundary_tag_allocator
  import sbta_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [9:0]          byte_count,
  input  logic [SLOT_W-1:0]   field_slot,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SLOT_W-1:0]   granted_slot,
  output logic                success,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_A_READ, ST_A_EVAL, ST_A_SPLIT, ST_X_READ, ST_X_EVAL, ST_X_CHK,
    ST_F_READ, ST_F_E0, ST_F_E1, ST_F_PREV, ST_F_E2, ST_F_HINT, ST_F_WR, ST_FIN
  } state_t;

  state_t            state;
  logic [PTR_W-1:0]  p;
  logic [NEED_W-1:0] need;
  logic [LEN_W-1:0]  mag;
  logic [TOTAL_W-1:0] total;
  logic [SLOT_W-1:0] search_start;
  logic [PTR_W-1:0]  used_end;
  logic [9:0]        heap_slots;
  logic              res_ok;
  logic [SLOT_W-1:0] res_slot;

  tag_wr_t           head_wr, tail_wr;
  logic [PTR_W-1:0]  head_raddr, tail_raddr;
  logic [TAG_W-1:0]  head_rd, tail_rd;

  // decoded tag read: sign and length (zero stepped over as one slot)
  logic              h_neg, t_neg;
  logic [LEN_W-1:0]  h_mag, h_len, t_mag;
  logic [PTR_W-1:0]  p_plus_len;
  logic [PTR_W-1:0]  lim;
  logic [10:0]       need_sum;
  logic [NEED_W-1:0] chunk;

  assign h_neg      = head_rd[TAG_W-1];
  assign h_mag      = h_neg ? LEN_W'(~head_rd + 1'b1) : head_rd;
  assign h_len      = (h_mag == '0) ? LEN_W'(1) : h_mag;
  assign t_neg      = tail_rd[TAG_W-1];
  assign t_mag      = t_neg ? LEN_W'(~tail_rd + 1'b1) : tail_rd;
  assign p_plus_len = p + PTR_W'(h_len);
  assign lim        = (heap_slots < PTR_W'(MAX_SLOTS)) ? heap_slots : PTR_W'(MAX_SLOTS);
  assign need_sum   = (11'({1'b0, byte_count}) + 11'(SLOT_BYTES + 1)) >> SLOT_SHIFT;
  assign chunk      = (total > TOTAL_W'(FIELD_MAX)) ? NEED_W'(FIELD_MAX) : NEED_W'(total);

  // read addresses
  always_comb begin
    head_raddr = p;
    tail_raddr = p - 1'b1;
    if (state == ST_F_E0) begin
      head_raddr = p_plus_len;
    end
  end

  // tag writes
  always_comb begin
    head_wr = '0;
    tail_wr = '0;
    case (state)
      ST_A_EVAL: begin
        if (h_neg && (h_len >= LEN_W'(need))) begin
          head_wr = '{1'b1, p, TAG_W'(need)};
          tail_wr = '{1'b1, p + PTR_W'(need) - 1'b1, TAG_W'(need)};
        end
      end
      ST_A_SPLIT: begin
        head_wr = '{1'b1, p + PTR_W'(need), TAG_W'(LEN_W'(need) - mag)};
        tail_wr = '{1'b1, p + PTR_W'(mag) - 1'b1, TAG_W'(LEN_W'(need) - mag)};
      end
      ST_X_CHK: begin
        if (!((p > lim) || ((lim - p) < PTR_W'(need)))) begin
          head_wr = '{1'b1, p, TAG_W'(need)};
          tail_wr = '{1'b1, p + PTR_W'(need) - 1'b1, TAG_W'(need)};
        end
      end
      ST_F_WR: begin
        head_wr = '{1'b1, p, TAG_W'(-$signed({1'b0, chunk}))};
        tail_wr = '{1'b1, p + PTR_W'(chunk) - 1'b1, TAG_W'(-$signed({1'b0, chunk}))};
      end
      default: begin
      end
    endcase
  end

  sbta_tag_ram #(.INIT_ADDR(0), .INIT_TAG(TAG_W'(-FIELD_MAX))) u_head (
    .clk(clk), .rst(rst), .wr(head_wr), .raddr(head_raddr), .rdata(head_rd)
  );

  sbta_tag_ram #(.INIT_ADDR(FIELD_MAX - 1), .INIT_TAG(TAG_W'(-FIELD_MAX))) u_tail (
    .clk(clk), .rst(rst), .wr(tail_wr), .raddr(tail_raddr), .rdata(tail_rd)
  );

  assign in_stall = (state != ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      search_start <= '0;
      used_end     <= PTR_W'(FIELD_MAX);
      out_valid    <= 1'b0;
      p            <= '0;
      need         <= '0;
      mag          <= '0;
      total        <= '0;
      res_ok       <= 1'b0;
      res_slot     <= '0;
      granted_slot <= '0;
      success      <= 1'b0;
    end else begin
      // ST_FIN reloads the output register itself
      if (out_valid && !out_stall && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            res_slot <= '0;
            res_ok   <= 1'b1;
            if (action == ACT_FREE) begin
              p     <= PTR_W'(field_slot);
              state <= ST_F_READ;
            end else if ((byte_count == '0) || (byte_count > 10'(MAX_BYTES))) begin
              res_ok <= 1'b0;
              state  <= ST_FIN;
            end else begin
              need  <= need_sum[NEED_W-1:0];
              p     <= PTR_W'(search_start);
              state <= ST_A_READ;
            end
          end
        end
        ST_A_READ: state <= ST_A_EVAL;
        ST_A_EVAL: begin
          mag <= h_len;
          if (h_neg && (h_len >= LEN_W'(need))) begin
            res_slot <= p[SLOT_W-1:0];
            state    <= (h_len > LEN_W'(need)) ? ST_A_SPLIT : ST_FIN;
          end else begin
            p     <= p_plus_len;
            state <= (p_plus_len < used_end) ? ST_A_READ : ST_X_READ;
          end
        end
        ST_A_SPLIT: state <= ST_FIN;
        ST_X_READ: state <= ST_X_EVAL;
        ST_X_EVAL: begin
          // absorb a trailing free field
          if (t_neg && (PTR_W'(t_mag) <= p)) begin
            p <= p - PTR_W'(t_mag);
          end
          state <= ST_X_CHK;
        end
        ST_X_CHK: begin
          if ((p > lim) || ((lim - p) < PTR_W'(need))) begin
            res_ok <= 1'b0;
          end else begin
            used_end <= p + PTR_W'(need);
            res_slot <= p[SLOT_W-1:0];
          end
          state <= ST_FIN;
        end
        ST_F_READ: state <= ST_F_E0;
        ST_F_E0: begin
          total <= TOTAL_W'(h_len);
          state <= (p_plus_len < used_end) ? ST_F_E1 : ST_F_PREV;
        end
        ST_F_E1: begin
          // upper neighbour
          if (h_neg) begin
            total <= total + TOTAL_W'(h_mag);
          end
          state <= ST_F_PREV;
        end
        ST_F_PREV: state <= (p != '0) ? ST_F_E2 : ST_F_HINT;
        ST_F_E2: begin
          // lower neighbour
          if (t_neg && (PTR_W'(t_mag) <= p)) begin
            p     <= p - PTR_W'(t_mag);
            total <= total + TOTAL_W'(t_mag);
          end
          state <= ST_F_HINT;
        end
        ST_F_HINT: begin
          if (p < PTR_W'(search_start)) begin
            search_start <= p[SLOT_W-1:0];
          end
          state <= ST_F_WR;
        end
        ST_F_WR: begin
          p     <= p + PTR_W'(chunk);
          total <= total - TOTAL_W'(chunk);
          if (total <= TOTAL_W'(FIELD_MAX)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            granted_slot <= res_slot;
            success      <= res_ok;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_slots <= 10'(MAX_SLOTS);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      heap_slots <= pwdata[9:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {22'd0, heap_slots};

  // checks
  a_used_end_range: assert property (@(posedge clk) disable iff (rst)
    used_end <= PTR_W'(MAX_SLOTS))
    else $error("used end beyond heap");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> (granted_slot == '0))
    else $error("failed allocation carries a slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("transaction accepted without entering the sequencer");

endmodule

// File: tb/slot_boundary_tag_allocator_test.sv
// self-checking testbench for slot_boundary_tag_allocator: directed, heap-limit and random tests
// depends on sbta_pkg and the allocator rtl; a built-in heap predictor supplies the expected results
module slot_boundary_tag_allocator_test;
  import sbta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_ALLOC;
  logic [9:0] byte_count = '0;
  logic [SLOT_W-1:0] field_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SLOT_W-1:0] granted_slot;
  logic success;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  slot_boundary_tag_allocator uut (.*);

  always #6 clk = ~clk;

  // shadow heap: boundary tags, search hint, used end and the size limit
  logic [TAG_W-1:0] heap_head [MAX_SLOTS];
  logic [TAG_W-1:0] heap_tail [MAX_SLOTS];
  int unsigned hint;
  int unsigned used_top;
  int unsigned heap_limit;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic ok;
  } grant_t;

  grant_t pending_grants[$];
  int errors = 0;
  int cycles = 0;
  int allocs_sent = 0;
  int frees_sent = 0;
  int grants_seen = 0;
  bit quiet = 0;       // no idling on either side during the closing stretch

  // live field heads, rebuilt from the shadow heap
  int unsigned used_heads[$];
  int unsigned free_heads[$];

  function automatic int tag_of(input logic [TAG_W-1:0] t);
    return $signed(t);
  endfunction

  function automatic int unsigned len_of(input int t);
    int unsigned m;
    m = t < 0 ? -t : t;
    return m == 0 ? 1 : m;
  endfunction

  function automatic int read_head(input int unsigned i);
    return i < MAX_SLOTS ? tag_of(heap_head[i]) : 0;
  endfunction

  function automatic int read_tail(input int unsigned i);
    return i < MAX_SLOTS ? tag_of(heap_tail[i]) : 0;
  endfunction

  function automatic void put_field(input int unsigned p, input int unsigned n, input int v);
    if (p < MAX_SLOTS) heap_head[p] = v[TAG_W-1:0];
    if (p + n - 1 < MAX_SLOTS) heap_tail[p + n - 1] = v[TAG_W-1:0];
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < MAX_SLOTS; i++) begin
      heap_head[i] = '0;
      heap_tail[i] = '0;
    end
    put_field(0, FIELD_MAX, -FIELD_MAX);
    hint = 0;
    used_top = FIELD_MAX;
    heap_limit = 512;
  endfunction

  // first fit from the hint, else grow the used end
  function automatic grant_t predict_alloc(input int unsigned n);
    grant_t g;
    int unsigned need, p, mag, lim;
    int t;
    g = '0;
    if (n == 0 || n > MAX_BYTES) return g;
    need = (n + 2 + SLOT_BYTES - 1) / SLOT_BYTES;
    p = hint;
    do begin
      t = read_head(p);
      mag = len_of(t);
      if (t < 0 && mag >= need) begin
        put_field(p, need, need);
        if (mag > need) put_field(p + need, mag - need, -(mag - need));
        g.slot = p[SLOT_W-1:0];
        g.ok = 1'b1;
        return g;
      end
      p += mag;
    end while (p < used_top);
    // a trailing free field is absorbed into the extension
    t = read_tail(p - 1);
    if (t < 0 && (-t) <= p) p -= -t;
    lim = heap_limit < MAX_SLOTS ? heap_limit : MAX_SLOTS;
    if (p > lim || lim - p < need) return g;
    put_field(p, need, need);
    used_top = p + need;
    g.slot = p[SLOT_W-1:0];
    g.ok = 1'b1;
    return g;
  endfunction

  // merge with free neighbours, rewrite as pieces of at most FIELD_MAX slots
  function automatic grant_t predict_release(input int unsigned p);
    grant_t g;
    int unsigned total, c;
    int t;
    total = len_of(read_head(p));
    if (p + total < used_top) begin
      t = read_head(p + total);
      if (t < 0) total += -t;
    end
    if (p > 0) begin
      t = read_tail(p - 1);
      if (t < 0 && (-t) <= p) begin
        p -= -t;
        total += -t;
      end
    end
    if (p < hint) hint = p;
    while (total > 0) begin
      c = total > FIELD_MAX ? FIELD_MAX : total;
      put_field(p, c, -c);
      p += c;
      total -= c;
    end
    g.slot = '0;
    g.ok = 1'b1;
    return g;
  endfunction

  function automatic void list_fields();
    int unsigned p;
    int t;
    used_heads.delete();
    free_heads.delete();
    p = 0;
    while (p < used_top) begin
      t = read_head(p);
      if (t > 0) used_heads.push_back(p);
      else free_heads.push_back(p);
      p += len_of(t);
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_grants.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      grants_seen++;
      if (pending_grants.size() == 0) begin
        errors++;
        $display("%t: unexpected result slot=%0d success=%0d", $realtime, granted_slot, success);
      end else begin
        want = pending_grants.pop_front();
        if (granted_slot !== want.slot) begin
          errors++;
          $display("%t: granted_slot expected %0d actual %0d", $realtime, want.slot,
                   granted_slot);
        end
        if (success !== want.ok) begin
          errors++;
          $display("%t: success expected %0d actual %0d", $realtime, want.ok, success);
        end
      end
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    forever begin
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (!quiet && !rst) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // one transaction on the input channel; prediction at acceptance
  task automatic send_request(input logic act, input int unsigned bytes, input int unsigned slot);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    byte_count = bytes[9:0];
    field_slot = slot[SLOT_W-1:0];
    do @(posedge clk); while (in_stall);
    if (act == ACT_ALLOC) begin
      pending_grants.push_back(predict_alloc(bytes[9:0]));
      allocs_sent++;
    end else begin
      pending_grants.push_back(predict_release(slot[SLOT_W-1:0]));
      frees_sent++;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // returns at a falling edge so that driving resumes there
  task automatic wait_drained();
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // write heap_slots then read it back, only while the block is idle
  task automatic set_heap_limit(input int unsigned value);
    wait_drained();
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = '0; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    heap_limit = value & 10'h3ff;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[9:0] !== value[9:0]) begin
      errors++;
      $display("%t: heap_slots read expected %0d actual %0d", $realtime, value, prdata[9:0]);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // size boundaries, rejected sizes, split, merge and a repeated free
  task automatic test_size_edges();
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_ALLOC, 6, 0);
    send_request(ACT_ALLOC, 7, 0);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_ALLOC, 1015, 0);
    send_request(ACT_ALLOC, 1023, 511);
    send_request(ACT_ALLOC, MAX_BYTES, 0);
    send_request(ACT_FREE, 0, 1);        // middle field, upper neighbour used
    send_request(ACT_FREE, 0, 0);        // merges with the upper free neighbour
    send_request(ACT_FREE, 0, 0);        // freeing a field that is already free
    send_request(ACT_ALLOC, 14, 1023);
    send_request(ACT_FREE, 0, 3);        // inside the field at slot 2 rather than at its head
    send_request(ACT_ALLOC, 100, 0);
    list_fields();
    foreach (used_heads[i]) send_request(ACT_FREE, 1023, used_heads[i]);
  endtask

  // smallest and largest limits, filled until allocation fails
  task automatic test_heap_limit();
    set_heap_limit(127);
    repeat (6) send_request(ACT_ALLOC, 150, 0);
    send_request(ACT_ALLOC, 1, 0);
    set_heap_limit(512);
    repeat (5) send_request(ACT_ALLOC, MAX_BYTES, 0);
    list_fields();
    send_request(ACT_FREE, 0, used_heads[1]);
    send_request(ACT_FREE, 0, used_heads[2]);  // long merged run across pieces
    send_request(ACT_FREE, 0, used_heads[0]);
  endtask

  // mostly alloc/free of live fields with random sizes, some rejects and repeated frees
  task automatic test_random_traffic(input int count);
    int unsigned r, b;
    for (int k = 0; k < count; k++) begin
      list_fields();
      r = $urandom_range(0, 99);
      if (r < 44 && used_heads.size() != 0) begin
        send_request(ACT_FREE, $urandom_range(0, 1023),
                     used_heads[$urandom_range(0, used_heads.size() - 1)]);
      end else if (r < 48 && free_heads.size() != 0) begin
        send_request(ACT_FREE, $urandom_range(0, 1023),
                     free_heads[$urandom_range(0, free_heads.size() - 1)]);
      end else if (r < 52) begin
        send_request(ACT_ALLOC, $urandom_range(0, 1) ? 0 : $urandom_range(1015, 1023),
                     $urandom_range(0, 511));
      end else begin
        b = $urandom_range(0, 9) == 0 ? $urandom_range(1, MAX_BYTES) : $urandom_range(1, 120);
        send_request(ACT_ALLOC, b, $urandom_range(0, 511));
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin
    heap_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_size_edges();
    test_heap_limit();
    set_heap_limit(300);
    test_random_traffic(500);
    wait_drained();        // sender holds off until every result is in
    set_heap_limit(127);
    test_random_traffic(250);
    set_heap_limit(512);
    test_random_traffic(700);
    quiet = 1;
    test_random_traffic(350);

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d allocations and %0d frees, %0d results checked, limits 127 to 512",
             allocs_sent, frees_sent, grants_seen);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sbta_pkg.sv
sv/sbta_tag_ram.sv
sv/slot_boundary_tag_allocator.sv
tb/slot_boundary_tag_allocator_test.sv
